/* rtl/pkt7_pkg.sv */
// ----------------------------------------------------------------------------
// pkt7_pkg
// Shared types, constants and helpers for the 7-in-8 bus packet encoder.
// ----------------------------------------------------------------------------
package pkt7_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  localparam logic [9:0] MAX_PAYLOAD = 10'd512;

  localparam logic [7:0] HDR_DEST   = 8'h80;
  localparam logic [7:0] HDR_AUX    = 8'h80;
  localparam logic [7:0] MSB_BIT    = 8'h80;
  localparam logic [7:0] TRAIL_MASK = 8'haa;
  localparam logic [7:0] TRAIL_MARK = 8'hc8;
  localparam logic [7:0] END_MARK   = 8'h00;

  // divide by seven as multiply by reciprocal, exact for lengths below 5461
  localparam logic [11:0] DIV7_MUL   = 12'd2341;
  localparam int          DIV7_SHIFT = 14;

  typedef logic [6:0][7:0] byte_row_t;

  // one unit of work for the back end: a header burst or a data part
  typedef struct packed {
    logic       is_hdr;
    logic       trailer;
    logic [2:0] count;
    logic [7:0] check;
    byte_row_t  bytes;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  function automatic logic [7:0] sync_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hff;
      3'd1:    b = 8'h3f;
      3'd2:    b = 8'hcf;
      3'd3:    b = 8'hf3;
      3'd4:    b = 8'hfc;
      3'd5:    b = 8'hff;
      3'd6:    b = 8'hc3;
      default: b = 8'hff;
    endcase
    return b;
  endfunction

endpackage

/* rtl/pkt7_fifo.sv */
// ----------------------------------------------------------------------------
// pkt7_fifo
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pkt7_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

/* rtl/pkt7_front.sv */
// ----------------------------------------------------------------------------
// pkt7_front
// Accepts items, tracks packet state and collects payload parts into commands.
// ----------------------------------------------------------------------------
module pkt7_front
  import pkt7_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       func,
  input  logic [7:0] data_byte,
  input  logic [6:0] src_id,
  input  logic [6:0] packet_type,
  input  logic [6:0] status_code,
  input  logic [9:0] data_length,
  output logic       push,
  output cmd_t       cmd
);

  byte_row_t  hold;
  logic [7:0] running_check;
  logic [2:0] odd_count;
  logic [6:0] groups_left;
  logic [2:0] fill_index;
  logic       in_odd_part;
  logic       packet_open;

  byte_row_t  hold_next;
  logic [7:0] running_check_next;
  logic [2:0] odd_count_next;
  logic [6:0] groups_left_next;
  logic [2:0] fill_index_next;
  logic       in_odd_part_next;
  logic       packet_open_next;

  logic [9:0]  len_c;
  logic [21:0] prod;
  logic [6:0]  len_groups;
  logic [9:0]  len_rem;
  logic [2:0]  len_odd;
  logic [2:0]  fill_inc;
  logic [6:0]  groups_dec;
  logic [7:0]  hdr_check;
  byte_row_t   hdr;

  always_comb begin
    len_c      = (data_length > MAX_PAYLOAD) ? MAX_PAYLOAD : data_length;
    prod       = 22'(len_c) * 22'(DIV7_MUL);
    len_groups = prod[DIV7_SHIFT+6:DIV7_SHIFT];
    len_rem    = len_c - (({3'b000, len_groups} << 3) - {3'b000, len_groups});
    len_odd    = len_rem[2:0];

    hdr[0] = HDR_DEST;
    hdr[1] = MSB_BIT | {1'b0, src_id};
    hdr[2] = MSB_BIT | {1'b0, packet_type};
    hdr[3] = HDR_AUX;
    hdr[4] = MSB_BIT | {1'b0, status_code};
    hdr[5] = MSB_BIT | {5'b00000, len_odd};
    hdr[6] = MSB_BIT | {1'b0, len_groups};
    hdr_check = hdr[0] ^ hdr[1] ^ hdr[2] ^ hdr[3] ^ hdr[4] ^ hdr[5] ^ hdr[6];

    fill_inc   = fill_index + 3'd1;
    groups_dec = groups_left - 7'd1;

    hold_next          = hold;
    running_check_next = running_check;
    odd_count_next     = odd_count;
    groups_left_next   = groups_left;
    fill_index_next    = fill_index;
    in_odd_part_next   = in_odd_part;
    packet_open_next   = packet_open;

    push = 1'b0;
    cmd  = '0;

    if (accept) begin
      if (func == FUNC_START) begin
        odd_count_next     = len_odd;
        groups_left_next   = len_groups;
        running_check_next = hdr_check;
        fill_index_next    = 3'd0;
        in_odd_part_next   = (len_odd != 3'd0);
        packet_open_next   = (len_c != 10'd0);
        push        = 1'b1;
        cmd.is_hdr  = 1'b1;
        cmd.trailer = (len_c == 10'd0);
        cmd.count   = 3'd7;
        cmd.check   = hdr_check;
        cmd.bytes   = hdr;
      end else if (packet_open) begin
        hold_next[fill_index] = data_byte;
        running_check_next    = running_check ^ data_byte;
        fill_index_next       = fill_inc;
        cmd.is_hdr = 1'b0;
        cmd.check  = running_check ^ data_byte;
        cmd.bytes  = hold_next;
        if (in_odd_part) begin
          if (fill_inc >= odd_count) begin
            push             = 1'b1;
            cmd.count        = odd_count;
            cmd.trailer      = (groups_left == 7'd0);
            in_odd_part_next = 1'b0;
            fill_index_next  = 3'd0;
            packet_open_next = (groups_left != 7'd0);
          end
        end else if (fill_inc == 3'd7) begin
          push             = 1'b1;
          cmd.count        = 3'd7;
          cmd.trailer      = (groups_dec == 7'd0);
          fill_index_next  = 3'd0;
          groups_left_next = groups_dec;
          packet_open_next = (groups_dec != 7'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_check <= '0;
      odd_count     <= '0;
      groups_left   <= '0;
      fill_index    <= '0;
      in_odd_part   <= 1'b0;
      packet_open   <= 1'b0;
    end else begin
      running_check <= running_check_next;
      odd_count     <= odd_count_next;
      groups_left   <= groups_left_next;
      fill_index    <= fill_index_next;
      in_odd_part   <= in_odd_part_next;
      packet_open   <= packet_open_next;
    end
  end

  a_idle_fill: assert property (@(posedge clk) disable iff (rst)
    !packet_open |-> fill_index == 3'd0)
    else $error("fill index nonzero outside packet");
  a_odd_in_packet: assert property (@(posedge clk) disable iff (rst)
    in_odd_part |-> packet_open && odd_count != 3'd0)
    else $error("odd part flagged without open packet");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_index != 3'd7)
    else $error("fill index past group size");

endmodule

/* rtl/pkt7_back.sv */
// ----------------------------------------------------------------------------
// pkt7_back
// Sequences queued commands into wire bytes through a registered output.
// ----------------------------------------------------------------------------
module pkt7_back
  import pkt7_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       packet_end
);

  localparam logic [1:0] PH_SYNC  = 2'd0;
  localparam logic [1:0] PH_MSB   = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  cmd_t       cur;
  logic       busy;
  logic [1:0] phase;
  logic [2:0] idx;

  logic       busy_next;
  logic [1:0] phase_next;
  logic [2:0] idx_next;

  logic       load;
  logic [7:0] msb;
  logic [7:0] byte_c;
  logic       last_c;
  logic       end_c;

  assign load  = !out_valid || !out_stall;
  assign q_pop = !busy && !q_empty;

  always_comb begin
    msb = MSB_BIT;
    for (int k = 0; k < 7; k++) begin
      if (3'(k) < cur.count) begin
        msb[6-k] = cur.bytes[k][7];
      end
    end
  end

  always_comb begin
    byte_c     = 8'h00;
    last_c     = 1'b0;
    end_c      = 1'b0;
    busy_next  = busy;
    phase_next = phase;
    idx_next   = idx;
    unique case (phase)
      PH_SYNC: begin
        byte_c = sync_byte(idx);
        if (idx == 3'd6) begin
          phase_next = PH_BODY;
          idx_next   = 3'd0;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      PH_MSB: begin
        byte_c     = msb;
        phase_next = PH_BODY;
        idx_next   = 3'd0;
      end
      PH_BODY: begin
        byte_c = cur.bytes[idx] | MSB_BIT;
        if (idx == cur.count - 3'd1) begin
          idx_next = 3'd0;
          if (cur.trailer) begin
            phase_next = PH_TRAIL;
          end else begin
            last_c    = 1'b1;
            busy_next = 1'b0;
          end
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      PH_TRAIL: begin
        case (idx[1:0])
          2'd0:    byte_c = cur.check | TRAIL_MASK;
          2'd1:    byte_c = {1'b0, cur.check[7:1]} | TRAIL_MASK;
          2'd2:    byte_c = TRAIL_MARK;
          default: byte_c = END_MARK;
        endcase
        if (idx[1:0] == 2'd3) begin
          last_c    = 1'b1;
          end_c     = 1'b1;
          busy_next = 1'b0;
          idx_next  = 3'd0;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      default: begin
        busy_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (busy && load) begin
      out_byte   <= byte_c;
      run_last   <= last_c;
      packet_end <= end_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_SYNC;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy  <= 1'b1;
        phase <= q_cmd.is_hdr ? PH_SYNC : PH_MSB;
        idx   <= '0;
      end else if (busy && load) begin
        busy  <= busy_next;
        phase <= phase_next;
        idx   <= idx_next;
      end
      if (load) begin
        out_valid <= busy;
      end
    end
  end

  a_end_is_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> out_byte == END_MARK && run_last)
    else $error("packet end not on final marker");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> busy)
    else $error("command popped but sequencer not busy");
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    busy && phase == PH_BODY |-> idx < cur.count)
    else $error("body index past part length");

endmodule

/* rtl/bus_packet_group7_encoder.sv */
// ----------------------------------------------------------------------------
// bus_packet_group7_encoder
// Serial bus packet encoder with 7-in-8 group coding and an XOR check.
//
// Input channel (in_valid / in_stall): func 0 starts a packet from src_id,
// packet_type, status_code and data_length (clamped to the maximum); func 1
// carries one payload byte and is dropped when no packet is open.
// Output channel (out_valid / out_stall): one wire byte per transfer;
// run_last marks the last byte caused by an input transfer, packet_end
// marks the closing 00 marker.
// A start transfer yields 14 bytes (18 for an empty packet). The payload
// transfer that completes a part of k bytes yields k+1 bytes, plus 4
// check/trailer bytes at the end of a packet. A transfer passes through
// the 2-entry command queue between front and back ends, the sequencer's
// command register and the output register. The output sequencer sends one
// byte per cycle while out_stall is low and loads a command only when idle.
// in_stall rises only when that queue is full. When out_stall is held the
// output register holds its byte and the queue fills behind it.
// Reset clears packet state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module bus_packet_group7_encoder
  import pkt7_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] data_byte,
  input  logic [6:0] src_id,
  input  logic [6:0] packet_type,
  input  logic [6:0] status_code,
  input  logic [9:0] data_length,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       packet_end
);

  logic             accept;
  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [CMD_W-1:0] q_data;
  cmd_t             q_cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_cmd    = cmd_t'(q_data);

  pkt7_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func),
    .data_byte   (data_byte),
    .src_id      (src_id),
    .packet_type (packet_type),
    .status_code (status_code),
    .data_length (data_length),
    .push        (push),
    .cmd         (push_cmd)
  );

  pkt7_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  pkt7_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .packet_end (packet_end)
  );

endmodule

/* test/bus_packet_group7_encoder_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_packet_group7_encoder_check
// Watches both channels of the packet encoder. Every accepted input transfer
// is run through a local copy of the encoder's packet state to produce the
// wire bytes it should cause. These are queued and compared in order, field
// by field, with the output transfers. Counts go back to the testbench top.
// ----------------------------------------------------------------------------
module bus_packet_group7_encoder_check
  import pkt7_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       func,
  input  logic [7:0] data_byte,
  input  logic [6:0] src_id,
  input  logic [6:0] packet_type,
  input  logic [6:0] status_code,
  input  logic [9:0] data_length,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       packet_end,
  output int         mismatches,
  output int         pending,
  output int         packets_opened,
  output int         payload_taken,
  output int         bytes_checked
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       closing;
  } wire_byte_t;

  // sync run and start byte, index 0 goes out first
  localparam logic [6:0][7:0] SYNC_SEQ =
    {8'hc3, 8'hff, 8'hfc, 8'hf3, 8'hcf, 8'h3f, 8'hff};

  wire_byte_t      wire_q[$];
  logic [6:0][7:0] part_bytes;
  logic [7:0]      xor_sum;
  logic [2:0]      odd_len;
  logic [2:0]      fill_pos;
  logic [6:0]      groups_due;
  logic            odd_phase;
  logic            open_pkt;

  function automatic void emit(input logic [7:0] v, input logic closing);
    wire_byte_t w;
    w.value   = v;
    w.last    = 1'b0;
    w.closing = closing;
    wire_q.push_back(w);
  endfunction

  function automatic void emit_trailer();
    emit(xor_sum | TRAIL_MASK, 1'b0);
    emit((xor_sum >> 1) | TRAIL_MASK, 1'b0);
    emit(TRAIL_MARK, 1'b0);
    emit(END_MARK, 1'b1);
    open_pkt = 1'b0;
  endfunction

  // msb collection byte, then the part's bytes with bit 7 forced
  function automatic void emit_part(input int count);
    logic [7:0] msb;
    msb = MSB_BIT;
    for (int k = 0; k < count; k++)
      msb = msb | ((part_bytes[k] >> (k + 1)) & (MSB_BIT >> (k + 1)));
    emit(msb, 1'b0);
    for (int k = 0; k < count; k++)
      emit(part_bytes[k] | MSB_BIT, 1'b0);
  endfunction

  task automatic encode_transfer();
    int              len;
    int              start_size;
    logic [6:0][7:0] hdr_row;
    wire_byte_t      w;
    start_size = wire_q.size();
    if (func == FUNC_START) begin
      len = (data_length > MAX_PAYLOAD) ? int'(MAX_PAYLOAD) : int'(data_length);
      odd_len    = 3'(len % 7);
      groups_due = 7'(len / 7);
      hdr_row = {MSB_BIT | 8'(groups_due), MSB_BIT | 8'(odd_len),
                 MSB_BIT | 8'(status_code), HDR_AUX, MSB_BIT | 8'(packet_type),
                 MSB_BIT | 8'(src_id), HDR_DEST};
      xor_sum = '0;
      for (int i = 0; i < 7; i++)
        emit(SYNC_SEQ[i], 1'b0);
      for (int i = 0; i < 7; i++) begin
        xor_sum = xor_sum ^ hdr_row[i];
        emit(hdr_row[i], 1'b0);
      end
      fill_pos  = '0;
      odd_phase = (odd_len != 0);
      open_pkt  = 1'b1;
      packets_opened++;
      if (len == 0)
        emit_trailer();
    end else if (open_pkt) begin
      payload_taken++;
      part_bytes[fill_pos] = data_byte;
      xor_sum  = xor_sum ^ data_byte;
      fill_pos = fill_pos + 3'd1;
      if (odd_phase) begin
        if (fill_pos >= odd_len) begin
          emit_part(int'(odd_len));
          odd_phase = 1'b0;
          fill_pos  = '0;
          if (groups_due == 0)
            emit_trailer();
        end
      end else if (fill_pos == 3'd7) begin
        emit_part(7);
        fill_pos   = '0;
        groups_due = groups_due - 7'd1;
        if (groups_due == 0)
          emit_trailer();
      end
    end
    if (wire_q.size() > start_size) begin
      w = wire_q.pop_back();
      w.last = 1'b1;
      wire_q.push_back(w);
    end
  endtask

  task automatic check_byte();
    wire_byte_t seen;
    wire_byte_t want;
    seen.value   = out_byte;
    seen.last    = run_last;
    seen.closing = packet_end;
    bytes_checked++;
    if (wire_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected transfer: byte %02h last %b end %b",
                 seen.value, seen.last, seen.closing);
    end else begin
      want = wire_q.pop_front();
      if (seen !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("byte %0d: expected %02h last %b end %b, got %02h last %b end %b",
                   bytes_checked, want.value, want.last, want.closing,
                   seen.value, seen.last, seen.closing);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wire_q.delete();
      part_bytes     = '0;
      xor_sum        = '0;
      odd_len        = '0;
      fill_pos       = '0;
      groups_due     = '0;
      odd_phase      = 1'b0;
      open_pkt       = 1'b0;
      mismatches     = 0;
      packets_opened = 0;
      payload_taken  = 0;
      bytes_checked  = 0;
    end else begin
      if (in_valid && !in_stall)
        encode_transfer();
      if (out_valid && !out_stall)
        check_byte();
    end
    pending = wire_q.size();
  end

endmodule

/* test/bus_packet_group7_encoder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_packet_group7_encoder_test
// Drives start and payload transfers into the packet encoder: a directed
// opening with empty, odd-only, full-group, overlong and abandoned packets,
// then random packets, broken packets and stray payload bytes, with random
// gaps and stalls and one long output hold-off. The checker does the scoring.
// ----------------------------------------------------------------------------
module bus_packet_group7_encoder_test;
  import pkt7_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 250;

  localparam logic [5:0][7:0] EDGE_BYTES =
    {8'haa, 8'h55, 8'h7f, 8'h80, 8'h00, 8'hff};

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       func        = FUNC_START;
  logic [7:0] data_byte   = '0;
  logic [6:0] src_id      = '0;
  logic [6:0] packet_type = '0;
  logic [6:0] status_code = '0;
  logic [9:0] data_length = '0;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       run_last;
  logic       packet_end;

  int   mismatches;
  int   pending;
  int   packets_opened;
  int   payload_taken;
  int   bytes_checked;
  int   sent     = 0;
  logic hold_req = 1'b0;

  always #2 clk = ~clk;

  bus_packet_group7_encoder u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .data_byte   (data_byte),
    .src_id      (src_id),
    .packet_type (packet_type),
    .status_code (status_code),
    .data_length (data_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .packet_end  (packet_end)
  );

  bus_packet_group7_encoder_check u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .data_byte      (data_byte),
    .src_id         (src_id),
    .packet_type    (packet_type),
    .status_code    (status_code),
    .data_length    (data_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .packet_end     (packet_end),
    .mismatches     (mismatches),
    .pending        (pending),
    .packets_opened (packets_opened),
    .payload_taken  (payload_taken),
    .bytes_checked  (bytes_checked)
  );

  // one input transfer; gaps are skipped in the quiet stretch
  task automatic offer(input logic f, input logic [7:0] d, input logic [6:0] s,
                       input logic [6:0] t, input logic [6:0] st,
                       input logic [9:0] len);
    if (!(sent >= 200 && sent < 300)) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    func        <= f;
    data_byte   <= d;
    src_id      <= s;
    packet_type <= t;
    status_code <= st;
    data_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic open_packet(input logic [6:0] s, input logic [6:0] t,
                             input logic [6:0] st, input logic [9:0] len);
    offer(FUNC_START, 8'($urandom), s, t, st, len);
  endtask

  task automatic put_byte(input logic [7:0] d);
    offer(FUNC_DATA, d, 7'($urandom), 7'($urandom), 7'($urandom), 10'($urandom));
  endtask

  task automatic feed(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  // output side: random stalls, one long hold-off, one quiet stretch
  initial begin : receiver
    int cyc;
    bit held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end
      if (cyc >= 1200 && cyc < 1700)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < 18);
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int len;
    bit big_done;
    big_done = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty packets with header fields at both extremes
    open_packet(7'd0, 7'd0, 7'd0, 10'd0);
    open_packet(7'd127, 7'd127, 7'd127, 10'd0);
    // payload with no packet open
    put_byte(8'hff);
    put_byte(8'h00);
    // odd part only, shortest and longest
    open_packet(7'd1, 7'd2, 7'd3, 10'd1);
    put_byte(8'h80);
    open_packet(7'd4, 7'd5, 7'd6, 10'd6);
    for (int i = 0; i < 6; i++)
      put_byte(EDGE_BYTES[i]);
    // overlong length, then abandoned by a new start of one full group
    open_packet(7'd127, 7'd0, 7'd127, 10'h3ff);
    feed(3);
    open_packet(7'd0, 7'd127, 7'd0, 10'd7);
    feed(7);

    hold_req <= 1'b1;
    while (sent < 380 || !big_done) begin
      pick = $urandom_range(99);
      if (!big_done && sent >= 300) begin
        big_done = 1'b1;
        // clamped length, one odd byte and nine full groups before the next start
        open_packet(7'($urandom), 7'($urandom), 7'($urandom),
                    10'($urandom_range(512, 1023)));
        feed(70);
      end else if (pick < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 21);
        open_packet(7'($urandom), 7'($urandom), 7'($urandom), 10'(len));
        feed(len);
      end else if (pick < 90) begin
        len = $urandom_range(2, 30);
        open_packet(7'($urandom), 7'($urandom), 7'($urandom), 10'(len));
        feed($urandom_range(0, len - 1));
      end else begin
        feed($urandom_range(1, 3));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("covered %0d input transfers: %0d packet starts, %0d payload bytes",
             sent, packets_opened, payload_taken);
    $display("compared %0d wire bytes, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
